@@ rtl/morphological_r_peak_detector_macros.svh @@
// Assertion helpers for the RTL.
`ifndef MORPHOLOGICAL_R_PEAK_DETECTOR_MACROS_SVH
`define MORPHOLOGICAL_R_PEAK_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MRPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mrpd_pkg.sv @@
`timescale 1ns / 1ps
package mrpd_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int HALF_WINDOW = 5;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  // padded power-of-two size of the max/min tree; pad entries are zero,
  // which matches the zero start value of both max and min
  localparam int TREE_N      = 1 << $clog2(WIN_LEN + 1);
  localparam int TREE_LVLS   = $clog2(TREE_N);
  // 10 / HALF_WINDOW is exact for a half window that divides 10
  localparam int MORPH_GAIN  = 10 / HALF_WINDOW;
  localparam int TV_W        = 17;
  localparam int POS_W       = 10;
  localparam int THR_W       = 16;
  // centre lags newest by HALF_WINDOW, the candidate minimum by one more
  localparam logic [POS_W-1:0] MID_LAG = POS_W'(HALF_WINDOW + 1);
  localparam logic [THR_W-1:0] R_THRESHOLD_RST = THR_W'(115);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TV_W-1:0]     tval_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [THR_W-1:0]           thr_t;

endpackage

@@ rtl/morphological_r_peak_detector.sv @@
`timescale 1ns / 1ps
// Morphological R-peak detector. One signed sample enters per beat and one
// result leaves per beat; with no stall on the output the block sustains one
// sample per clock, which passes the sample window register, then the
// max/min tree, transform and peak compare into the result register.
// transform_value belongs to the window centre, HALF_WINDOW samples behind
// the newest one. peak_position is the ring index of the detected minimum
// (or the first sample of a flat minimum) and reads zero with no peak.
// r_threshold may be written only while no sample is in flight.
module morphological_r_peak_detector (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  mrpd_pkg::thr_t    cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrpd_pkg::sample_t in_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output mrpd_pkg::tval_t   out_transform_value,
  output logic              out_peak_found,
  output mrpd_pkg::pos_t    out_peak_position
);
  import mrpd_pkg::*;

  logic  in_acc;
  logic  adv;
  logic  s1_vld_r, s1_vld_nxt;
  logic  out_vld_r, out_vld_nxt;
  thr_t  thr_r;
  tval_t tval;
  tval_t older_r, mid_r;
  tval_t limit;
  pos_t  pos_r;
  pos_t  mid_pos;
  pos_t  plat_start_r, plat_start_nxt;
  logic  plat_open_r, plat_open_nxt;
  logic  found_nxt;
  pos_t  where_nxt;
  tval_t out_tv_r;
  logic  out_found_r;
  pos_t  out_pos_r;

  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  mrpd_morph u_morph (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (in_acc),
    .sample_in (in_sample),
    .tval      (tval)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r && out_stall;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end
  end

  assign limit   = tval_t'(0) - tval_t'({1'b0, thr_r});
  assign mid_pos = pos_r - MID_LAG;

  always_comb begin
    found_nxt      = 1'b0;
    where_nxt      = '0;
    plat_start_nxt = plat_start_r;
    plat_open_nxt  = plat_open_r;
    if (older_r > mid_r && mid_r < tval && mid_r < limit) begin
      found_nxt = 1'b1;
      where_nxt = mid_pos;
    end
    // descent onto an equal value opens a flat bottom
    if (older_r > mid_r && mid_r == tval) begin
      plat_start_nxt = mid_pos;
      plat_open_nxt  = 1'b1;
    end
    if (older_r == mid_r && mid_r < tval && plat_open_r && mid_r < limit) begin
      found_nxt = 1'b1;
      where_nxt = plat_start_r;
    end
    if (mid_r < tval) begin
      plat_open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      thr_r        <= R_THRESHOLD_RST;
      older_r      <= '0;
      mid_r        <= '0;
      pos_r        <= '0;
      plat_start_r <= '0;
      plat_open_r  <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (adv) begin
        older_r      <= mid_r;
        mid_r        <= tval;
        pos_r        <= pos_r + 1'b1;
        plat_start_r <= plat_start_nxt;
        plat_open_r  <= plat_open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tv_r    <= tval;
      out_found_r <= found_nxt;
      out_pos_r   <= where_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_transform_value = out_tv_r;
  assign out_peak_found      = out_found_r;
  assign out_peak_position   = out_pos_r;

`include "morphological_r_peak_detector_macros.svh"

  `MRPD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_vld_r, "stall with empty stage")
  `MRPD_ASSERT_NEXT(a_adv_loads_out, adv, out_vld_r, "result lost on advance")
  `MRPD_ASSERT_NEXT(a_peak_closes_plateau, adv && found_nxt, !plat_open_r,
                    "plateau still open after peak")
  `MRPD_ASSERT_NEXT(a_pos_steps, adv, pos_r == $past(pos_r) + 1'b1,
                    "position counter out of step")
  `MRPD_ASSERT_NOW(a_no_peak_no_pos, out_vld_r && !out_found_r, out_pos_r == '0,
                   "position set without peak")

endmodule

@@ rtl/mrpd_morph.sv @@
`timescale 1ns / 1ps
module mrpd_morph (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  mrpd_pkg::sample_t sample_in,
  output mrpd_pkg::tval_t  tval
);
  import mrpd_pkg::*;

  sample_t win_r   [WIN_LEN];
  sample_t win_nxt [WIN_LEN];
  sample_t mx [TREE_N];
  sample_t mn [TREE_N];
  sample_t hi;
  sample_t lo;
  tval_t   diff;

  // oldest sample at index 0, newest at the top
  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[WIN_LEN-1] = sample_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // balanced max/min trees, reduced in place level by level
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      mx[i] = '0;
      mn[i] = '0;
    end
    for (int i = 0; i < WIN_LEN; i++) begin
      mx[i] = win_r[i];
      mn[i] = win_r[i];
    end
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
        mx[i] = (mx[2*i] > mx[2*i+1]) ? mx[2*i] : mx[2*i+1];
        mn[i] = (mn[2*i] < mn[2*i+1]) ? mn[2*i] : mn[2*i+1];
      end
    end
    hi = mx[0];
    lo = mn[0];
  end

  assign diff = tval_t'(hi) + tval_t'(lo) - (tval_t'(win_r[HALF_WINDOW]) <<< 1);
  assign tval = tval_t'(diff * MORPH_GAIN);

endmodule
